[sv/ufrb_pkg.sv]
// Shared constants and types for the disjoint-set table with undo.
`default_nettype none
package ufrb_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = $clog2(NODES);
  localparam int ENT_W  = NODE_W + 1;
  localparam int CNT_W  = $clog2(NODES + 1);

  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_MERGE = 2'd1;
  localparam logic [1:0] CMD_UNDO  = 2'd2;

  // One undo record: the root that was hung, its new parent, and its former entry.
  typedef struct packed {
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] root;
    logic [ENT_W-1:0]  old_entry;
  } undo_rec_t;

endpackage
`default_nettype wire

[sv/union_find_with_rollback_top.sv]
// Disjoint-set table with union by size, no path compression, and an undo stack.
//
// The input channel (in_valid_i/in_ready_o) carries a command and two node indexes.
// A query returns both roots and whether they match; a merge of two distinct sets also
// hangs the smaller set's root under the larger one (node_a's root on a tie) and pushes an
// undo record; an undo pops the last record and restores both roots, or flags error on an
// empty stack. Each command gives exactly one transfer on the output channel
// (out_valid_o/out_ready_i).
// The walks read the parent table once per level, first node_a's path and then node_b's;
// union by size keeps depths within 10 with 1024 nodes. A merge adds two writes, the
// root's new size and then the child's parent; an undo reads its record, rewrites the
// root and then the child, or goes straight to the result on an empty stack.
// One command is in flight at a time.
// After reset the parent table is swept to all singletons, one entry per cycle, over all
// 1024 entries; in_ready_o stays low until the sweep is done.
// The result sits in an output register, so the next command is taken while it waits;
// if the receiver stalls, the following result waits until the register frees.
`default_nettype none
module union_find_with_rollback_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [ufrb_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [ufrb_pkg::NODE_W-1:0] node_b_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ufrb_pkg::NODE_W-1:0]      root_a_o,
  output logic [ufrb_pkg::NODE_W-1:0]      root_b_o,
  output logic                             same_set_o,
  output logic                             merged_o,
  output logic                             error_o
);
  import ufrb_pkg::*;

  localparam logic [3:0] ST_CLEAR       = 4'd0;
  localparam logic [3:0] ST_IDLE        = 4'd1;
  localparam logic [3:0] ST_WALK_A      = 4'd2;
  localparam logic [3:0] ST_WALK_B      = 4'd3;
  localparam logic [3:0] ST_MERGE_ROOT  = 4'd4;
  localparam logic [3:0] ST_MERGE_CHILD = 4'd5;
  localparam logic [3:0] ST_UNDO_REC    = 4'd6;
  localparam logic [3:0] ST_UNDO_ROOT   = 4'd7;
  localparam logic [3:0] ST_UNDO_CHILD  = 4'd8;
  localparam logic [3:0] ST_RESULT      = 4'd9;

  // Memories.
  logic [ENT_W-1:0]  pt_mem [NODES];
  undo_rec_t         us_mem [NODES];
  logic [ENT_W-1:0]  pt_rd_q;
  undo_rec_t         us_rd_q;

  logic [3:0]        state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [NODE_W-1:0] node_b_q, node_b_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [ENT_W-1:0]  ent_a_q, ent_a_d;
  logic [NODE_W-1:0] child_q, child_d, root_q, root_d;
  logic [ENT_W-1:0]  child_ent_q, child_ent_d, root_ent_q, root_ent_d;
  logic              same_q, same_d, merged_q, merged_d, err_q, err_d;

  logic              out_valid_q;
  logic [NODE_W-1:0] out_ra_q, out_rb_q;
  logic              out_same_q, out_merged_q, out_err_q;
  logic              out_load;

  logic              pt_we;
  logic [NODE_W-1:0] pt_wr_addr, pt_rd_addr;
  logic [ENT_W-1:0]  pt_wr_data;
  logic              us_we;
  logic [NODE_W-1:0] us_rd_addr;
  logic [CNT_W-1:0]  cnt_m1;
  logic              in_xfer;
  logic              ent_root;
  logic [NODE_W-1:0] next_ptr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cnt_m1     = count_q - CNT_W'(1);
  assign us_rd_addr = cnt_m1[NODE_W-1:0];
  assign ent_root   = pt_rd_q[ENT_W-1];
  assign next_ptr   = pt_rd_q[NODE_W-1:0];
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    node_b_d    = node_b_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    ent_a_d     = ent_a_q;
    child_d     = child_q;
    root_d      = root_q;
    child_ent_d = child_ent_q;
    root_ent_d  = root_ent_q;
    same_d      = same_q;
    merged_d    = merged_q;
    err_d       = err_q;
    pt_we       = 1'b0;
    pt_wr_addr  = child_q;
    pt_wr_data  = child_ent_q;
    pt_rd_addr  = cur_q;
    us_we       = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        pt_we      = 1'b1;
        pt_wr_addr = clr_q;
        pt_wr_data = '1;
        if (clr_q == NODE_W'(NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + NODE_W'(1);
        end
      end
      ST_IDLE: begin
        pt_rd_addr = node_a_i;
        if (in_xfer) begin
          cmd_d    = command_i;
          node_b_d = node_b_i;
          cur_d    = node_a_i;
          ra_d     = '0;
          rb_d     = '0;
          same_d   = 1'b0;
          merged_d = 1'b0;
          err_d    = 1'b0;
          if (command_i == CMD_UNDO) begin
            if (count_q == '0) begin
              err_d   = 1'b1;
              state_d = ST_RESULT;
            end else begin
              count_d = cnt_m1;
              state_d = ST_UNDO_REC;
            end
          end else begin
            state_d = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        if (ent_root) begin
          ra_d       = cur_q;
          ent_a_d    = pt_rd_q;
          cur_d      = node_b_q;
          pt_rd_addr = node_b_q;
          state_d    = ST_WALK_B;
        end else begin
          cur_d      = next_ptr;
          pt_rd_addr = next_ptr;
        end
      end
      ST_WALK_B: begin
        if (ent_root) begin
          rb_d   = cur_q;
          same_d = (ra_q == cur_q);
          // The larger set (more negative entry) keeps its root; a tie hangs node_a's root.
          if ($signed(ent_a_q) < $signed(pt_rd_q)) begin
            child_d     = cur_q;
            root_d      = ra_q;
            child_ent_d = pt_rd_q;
            root_ent_d  = ent_a_q;
          end else begin
            child_d     = ra_q;
            root_d      = cur_q;
            child_ent_d = ent_a_q;
            root_ent_d  = pt_rd_q;
          end
          if (cmd_q == CMD_MERGE && ra_q != cur_q && count_q < CNT_W'(NODES)) begin
            state_d = ST_MERGE_ROOT;
          end else begin
            state_d = ST_RESULT;
          end
        end else begin
          cur_d      = next_ptr;
          pt_rd_addr = next_ptr;
        end
      end
      ST_MERGE_ROOT: begin
        pt_we      = 1'b1;
        pt_wr_addr = root_q;
        pt_wr_data = root_ent_q + child_ent_q;
        us_we      = 1'b1;
        count_d    = count_q + CNT_W'(1);
        merged_d   = 1'b1;
        state_d    = ST_MERGE_CHILD;
      end
      ST_MERGE_CHILD: begin
        pt_we      = 1'b1;
        pt_wr_addr = child_q;
        pt_wr_data = {1'b0, root_q};
        state_d    = ST_RESULT;
      end
      ST_UNDO_REC: begin
        child_d     = us_rd_q.child;
        root_d      = us_rd_q.root;
        child_ent_d = us_rd_q.old_entry;
        pt_rd_addr  = us_rd_q.root;
        state_d     = ST_UNDO_ROOT;
      end
      ST_UNDO_ROOT: begin
        pt_we      = 1'b1;
        pt_wr_addr = root_q;
        pt_wr_data = pt_rd_q - child_ent_q;
        state_d    = ST_UNDO_CHILD;
      end
      ST_UNDO_CHILD: begin
        pt_we      = 1'b1;
        pt_wr_addr = child_q;
        pt_wr_data = child_ent_q;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Parent table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_wr_addr] <= pt_wr_data;
    end
    pt_rd_q <= pt_mem[pt_rd_addr];
  end

  // Undo stack: pushed at the current count, read at the top entry.
  always_ff @(posedge clk_i) begin
    if (us_we) begin
      us_mem[count_q[NODE_W-1:0]] <= '{child: child_q, root: root_q, old_entry: child_ent_q};
    end
    us_rd_q <= us_mem[us_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    node_b_q    <= node_b_d;
    cur_q       <= cur_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    ent_a_q     <= ent_a_d;
    child_q     <= child_d;
    root_q      <= root_d;
    child_ent_q <= child_ent_d;
    root_ent_q  <= root_ent_d;
    same_q      <= same_d;
    merged_q    <= merged_d;
    err_q       <= err_d;
    if (out_load) begin
      out_ra_q     <= ra_q;
      out_rb_q     <= rb_q;
      out_same_q   <= same_q;
      out_merged_q <= merged_q;
      out_err_q    <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_a_o    = out_ra_q;
  assign root_b_o    = out_rb_q;
  assign same_set_o  = out_same_q;
  assign merged_o    = out_merged_q;
  assign error_o     = out_err_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NODES))
    else $error("undo count exceeds the node count");

  a_merge_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MERGE_ROOT |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("merge did not push exactly one undo record");

  a_merge_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> !same_set_o && !error_o)
    else $error("merged result also reports same set or error");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> root_a_o == '0 && root_b_o == '0 && !merged_o)
    else $error("failed undo carries nonzero fields");

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the disjoint-set table with union by size and undo.
`timescale 1ns / 1ps
module tb_top;
  import ufrb_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic              same_set;
    logic              merged;
    logic              err_flag;
  } outcome_t;

  // Mirror of the parent table and undo stack; predicts one outcome per command.
  class dsu_checker;
    int parent [NODES];
    int undo_child [NODES];
    int undo_root [NODES];
    int undo_old [NODES];
    int undo_depth;
    int errors;
    outcome_t expected_outcomes[$];

    function new();
      for (int i = 0; i < NODES; i++) parent[i] = -1;
      undo_depth = 0;
      errors = 0;
    endfunction

    function int find_root(int n);
      int cur;
      cur = n;
      for (int guard = 0; guard < NODES; guard++) begin
        if (parent[cur] < 0) break;
        cur = parent[cur];
      end
      return cur;
    endfunction

    function void accept_command(logic [1:0] cmd, int a, int b);
      outcome_t o;
      int ra, rb, child, root;
      o = '0;
      if (cmd == CMD_UNDO) begin
        if (undo_depth == 0) begin
          o.err_flag = 1'b1;
        end else begin
          undo_depth--;
          parent[undo_root[undo_depth]] -= undo_old[undo_depth];
          parent[undo_child[undo_depth]] = undo_old[undo_depth];
        end
      end else begin
        ra = find_root(a);
        rb = find_root(b);
        o.root_a = NODE_W'(ra);
        o.root_b = NODE_W'(rb);
        o.same_set = (ra == rb);
        if (cmd == CMD_MERGE && ra != rb && undo_depth < NODES) begin
          // The smaller set is hung; on a tie the root of node_a becomes the child.
          child = ra;
          root = rb;
          if (parent[ra] < parent[rb]) begin
            child = rb;
            root = ra;
          end
          undo_child[undo_depth] = child;
          undo_root[undo_depth] = root;
          undo_old[undo_depth] = parent[child];
          undo_depth++;
          parent[root] += parent[child];
          parent[child] = root;
          o.merged = 1'b1;
        end
      end
      expected_outcomes.insert(expected_outcomes.size(), o);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void compare_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_outcomes.pop_front();
      check_field("root_a", int'(want.root_a), int'(got.root_a));
      check_field("root_b", int'(want.root_b), int'(got.root_b));
      check_field("same_set", int'(want.same_set), int'(got.same_set));
      check_field("merged", int'(want.merged), int'(got.merged));
      check_field("error", int'(want.err_flag), int'(got.err_flag));
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = CMD_QUERY;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [NODE_W-1:0] root_a;
  logic [NODE_W-1:0] root_b;
  logic              same_set;
  logic              merged;
  logic              err_flag;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  dsu_checker sb = new();

  union_find_with_rollback_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .node_a_i    (node_a),
    .node_b_i    (node_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .root_a_o    (root_a),
    .root_b_o    (root_b),
    .same_set_o  (same_set),
    .merged_o    (merged),
    .error_o     (err_flag)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.compare_outcome('{root_a, root_b, same_set, merged, err_flag});
    end
  end

  task automatic send_item(input logic [1:0] cmd, input int a, input int b);
    logic [NODE_W-1:0] na;
    logic [NODE_W-1:0] nb;
    na = NODE_W'(a);
    nb = NODE_W'(b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    node_a <= na;
    node_b <= nb;
    do @(posedge clk_i); while (!in_ready);
    sb.accept_command(cmd, int'(na), int'(nb));
  endtask

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CMD_QUERY;
    else if (r < 80) return CMD_MERGE;
    else if (r < 95) return CMD_UNDO;
    else return CMD_SPARE;
  endfunction

  // Draws nearly half the time from a pool of low indexes so that sets grow deep, with the
  // extremes and the full range mixed in.
  function automatic int pick_node(int pool);
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? NODES - 1 : 0;
    else if (r < 55) return $urandom_range(pool);
    else return $urandom_range(NODES - 1);
  endfunction

  task automatic run_random(input int count, input int pool);
    int sent;
    int burst;
    logic [1:0] cmd;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 3) begin
        // A run of undos unwinds a good part of the stack, sometimes all of it.
        burst = $urandom_range(40, 5);
        repeat (burst) send_item(CMD_UNDO, $urandom, $urandom);
        sent += burst;
      end else begin
        cmd = pick_command();
        send_item(cmd, pick_node(pool), pick_node(pool));
        sent++;
      end
    end
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int idle_of [5];
    int stall_of [5];
    int pool_of [5];
    idle_of = '{0, 70, 0, 28, 0};
    stall_of = '{0, 0, 70, 28, 0};
    pool_of = '{NODES - 1, 63, NODES - 1, 255, NODES - 1};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: singletons, ties, same-root merges, deep finds, undo to empty.
    send_item(CMD_QUERY, 0, NODES - 1);
    send_item(CMD_MERGE, 0, 1);
    send_item(CMD_MERGE, 1, 0);
    send_item(CMD_QUERY, 0, 1);
    send_item(CMD_MERGE, 2, 3);
    send_item(CMD_MERGE, 3, 0);
    send_item(CMD_MERGE, NODES - 1, 0);
    send_item(CMD_QUERY, NODES - 1, 2);
    send_item(CMD_SPARE, NODES - 1, 3);
    send_item(CMD_MERGE, 512, 511);
    send_item(CMD_MERGE, 511, NODES - 1);
    send_item(CMD_UNDO, 0, 0);
    send_item(CMD_UNDO, NODES - 1, NODES - 1);
    send_item(CMD_UNDO, 0, 0);
    send_item(CMD_QUERY, 0, NODES - 1);
    repeat (5) send_item(CMD_UNDO, 0, 0);
    send_item(CMD_SPARE, 682, 341);
    send_item(CMD_MERGE, 341, 682);
    send_item(CMD_QUERY, 682, 341);
    send_item(CMD_UNDO, 0, 0);

    for (int p = 0; p < 5; p++) begin
      send_idle_pct = idle_of[p];
      recv_stall_pct = stall_of[p];
      // Last phase: the receiver holds off long enough for the input to back up.
      if (p == 4) holds_asked++;
      run_random(325, pool_of[p]);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ufrb_pkg.sv
sv/union_find_with_rollback_top.sv
test/tb_top.sv
